// ===== design/grid_flood_fill_counter_unit_assert.svh =====
// assertion macros used by the flood fill counter walker
`ifndef GRID_FLOOD_FILL_COUNTER_UNIT_ASSERT_SVH
`define GRID_FLOOD_FILL_COUNTER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// property that must hold at every rising clock edge out of reset
`define GFFC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// implication checked in the same cycle
`define GFFC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define GFFC_ASSERT(lbl, prop, msg)
`define GFFC_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

// ===== design/gffc_pkg.sv =====
// shared constants and types for the flood fill counter
`timescale 1ns / 1ps

package gffc_pkg;

    // grid geometry
    localparam int MAX_ROWS   = 64;
    localparam int MAX_COLS   = 64;
    localparam int CELL_COUNT = MAX_ROWS * MAX_COLS;
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int CELL_W     = $clog2(CELL_COUNT);
    localparam int DEPTH_W    = $clog2(CELL_COUNT + 1);

    // field widths of the channels
    localparam int ROW_IN_W = 6;
    localparam int COL_IN_W = 6;
    localparam int SIZE_W   = 13;
    localparam int CFG_W    = 7;

    // width that holds any row or column limit
    localparam int MAX_DIM = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int DIM_W   = $clog2(MAX_DIM + 1);
    localparam int LIM_W   = (DIM_W > CFG_W) ? DIM_W : CFG_W;

    // visited tag width; a full tag sweep runs when it wraps
    localparam int EPOCH_W = 8;

    // register port
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 3;
    localparam int REG_IDX_W = ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_GRID_ROWS = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_GRID_COLS = 1'b1;

    // item kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_FILL = 1'b1;

    typedef struct packed {
        logic                kind;
        logic [ROW_IN_W-1:0] row;
        logic [COL_IN_W-1:0] col;
        logic                blocked;
    } item_t;

    typedef struct packed {
        logic [SIZE_W-1:0] region_size;
        logic              start_open;
    } result_t;

endpackage

// ===== design/gffc_if.sv =====
// item and result channel interfaces
`timescale 1ns / 1ps

interface gffc_item_if;
    import gffc_pkg::*;

    logic                valid;
    logic                ready;
    logic                kind;
    logic [ROW_IN_W-1:0] row;
    logic [COL_IN_W-1:0] col;
    logic                blocked;

    modport source (output valid, kind, row, col, blocked, input ready);
    modport sink (input valid, kind, row, col, blocked, output ready);
endinterface

interface gffc_result_if;
    import gffc_pkg::*;

    logic              valid;
    logic              ready;
    logic [SIZE_W-1:0] region_size;
    logic              start_open;

    modport source (output valid, region_size, start_open, input ready);
    modport sink (input valid, region_size, start_open, output ready);
endinterface

// ===== design/gffc_walker.sv =====
// cell map memory, coordinate stack and the fill sequencer
`timescale 1ns / 1ps
`include "grid_flood_fill_counter_unit_assert.svh"

module gffc_walker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    input  gffc_pkg::item_t            item,
    output logic                       item_ready,
    input  logic [gffc_pkg::LIM_W-1:0] rows_lim,
    input  logic [gffc_pkg::LIM_W-1:0] cols_lim,
    output logic                       res_valid,
    input  logic                       res_ready,
    output gffc_pkg::result_t          res
);
    import gffc_pkg::*;

    localparam int SWEEP_W = CELL_W + 1;

    // neighbor order of a probe round
    localparam logic [1:0] NB_DOWN  = 2'd0;
    localparam logic [1:0] NB_UP    = 2'd1;
    localparam logic [1:0] NB_RIGHT = 2'd2;
    localparam logic [1:0] NB_LEFT  = 2'd3;

    typedef enum logic [8:0] {
        ST_CLEAR = 9'b000000001,
        ST_IDLE  = 9'b000000010,
        ST_WRAP  = 9'b000000100,
        ST_START = 9'b000001000,
        ST_CHECK = 9'b000010000,
        ST_POP   = 9'b000100000,
        ST_CELL  = 9'b001000000,
        ST_PROBE = 9'b010000000,
        ST_DONE  = 9'b100000000
    } state_t;

    typedef struct packed {
        logic               wall;
        logic [EPOCH_W-1:0] tag;
    } cell_word_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } coord_t;

    function automatic logic [CELL_W-1:0] cell_addr(input logic [LIM_W-1:0] r,
                                                    input logic [LIM_W-1:0] c);
        logic [CELL_W-1:0] ra;
        logic [CELL_W-1:0] ca;
        ra = CELL_W'(r);
        ca = CELL_W'(c);
        return CELL_W'(ra * CELL_W'(MAX_COLS)) + ca;
    endfunction

    // memories
    cell_word_t cell_mem [CELL_COUNT];
    coord_t     stack_mem [CELL_COUNT];
    cell_word_t cell_rd_reg;
    coord_t     stack_rd_reg;

    logic              mem_we, mem_re;
    logic [CELL_W-1:0] mem_waddr, mem_raddr;
    cell_word_t        mem_wdata;
    logic              stk_we, stk_re;
    logic [CELL_W-1:0] stk_waddr, stk_raddr;
    coord_t            stk_wdata;

    // sequencer state
    state_t             state_reg, state_next;
    logic [SWEEP_W-1:0] sweep_reg, sweep_next;
    logic [EPOCH_W-1:0] epoch_reg, epoch_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [DEPTH_W-1:0] count_reg, count_next;
    logic               open_reg, open_next;
    logic [1:0]         probe_reg, probe_next;
    logic               nb_ok_reg, nb_ok_next;
    coord_t             cur_reg, cur_next;
    coord_t             nb_reg, nb_next;
    logic [CELL_W-1:0]  nb_addr_reg, nb_addr_next;
    logic [LIM_W-1:0]   start_row_reg, start_row_next;
    logic [LIM_W-1:0]   start_col_reg, start_col_next;

    // combinational helpers
    logic [DEPTH_W-1:0] depth_dec;
    logic [SWEEP_W-1:0] sweep_dec;
    coord_t             base;
    logic [1:0]         nb_sel;
    logic [LIM_W-1:0]   nb_row, nb_col;
    logic               nb_exist, nb_in;
    logic               push_hit;
    logic               start_in;
    logic [LIM_W-1:0]   load_row, load_col;
    logic               load_in;
    logic [CELL_W-1:0]  start_addr;

    assign depth_dec  = depth_reg - DEPTH_W'(1);
    assign sweep_dec  = sweep_reg - SWEEP_W'(1);
    assign start_in   = (start_row_reg < rows_lim) && (start_col_reg < cols_lim);
    assign start_addr = cell_addr(start_row_reg, start_col_reg);
    assign load_row   = LIM_W'(item.row);
    assign load_col   = LIM_W'(item.col);
    assign load_in    = (load_row < rows_lim) && (load_col < cols_lim);
    assign push_hit   = nb_ok_reg && !cell_rd_reg.wall && (cell_rd_reg.tag != epoch_reg);

    // neighbor for the next probe slot: of the popped cell in ST_CELL, else of the current cell
    always_comb
    begin
        base   = (state_reg == ST_CELL) ? stack_rd_reg : cur_reg;
        nb_sel = (state_reg == ST_CELL) ? NB_DOWN : (probe_reg + 2'd1);
        nb_row = LIM_W'(base.row);
        nb_col = LIM_W'(base.col);
        nb_exist = 1'b1;
        unique case (nb_sel)
            NB_DOWN:  nb_row = LIM_W'(base.row) + LIM_W'(1);
            NB_UP:
            begin
                nb_row   = LIM_W'(base.row) - LIM_W'(1);
                nb_exist = (base.row != '0);
            end
            NB_RIGHT: nb_col = LIM_W'(base.col) + LIM_W'(1);
            NB_LEFT:
            begin
                nb_col   = LIM_W'(base.col) - LIM_W'(1);
                nb_exist = (base.col != '0);
            end
            default:  nb_exist = 1'b0;
        endcase
        nb_in = nb_exist && (nb_row < rows_lim) && (nb_col < cols_lim);
    end

    assign item_ready = (state_reg == ST_IDLE);
    assign res_valid  = (state_reg == ST_DONE);
    assign res.region_size = SIZE_W'(count_reg);
    assign res.start_open  = open_reg;

    // fill sequencer
    always_comb
    begin
        state_next     = state_reg;
        sweep_next     = sweep_reg;
        epoch_next     = epoch_reg;
        depth_next     = depth_reg;
        count_next     = count_reg;
        open_next      = open_reg;
        probe_next     = probe_reg;
        nb_ok_next     = nb_ok_reg;
        cur_next       = cur_reg;
        nb_next        = nb_reg;
        nb_addr_next   = nb_addr_reg;
        start_row_next = start_row_reg;
        start_col_next = start_col_reg;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = '0;
        stk_we    = 1'b0;
        stk_waddr = depth_reg[CELL_W-1:0];
        stk_wdata = '0;
        stk_re    = 1'b0;
        stk_raddr = depth_dec[CELL_W-1:0];

        unique case (state_reg)
            // walls open and tags cleared after reset
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = sweep_reg[CELL_W-1:0];
                if (sweep_reg == SWEEP_W'(CELL_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
                sweep_next = sweep_reg + SWEEP_W'(1);
            end
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    if (item.kind == KIND_LOAD)
                    begin
                        mem_we         = load_in;
                        mem_waddr      = cell_addr(load_row, load_col);
                        mem_wdata.wall = item.blocked;
                    end
                    else
                    begin
                        start_row_next = load_row;
                        start_col_next = load_col;
                        depth_next     = '0;
                        count_next     = '0;
                        open_next      = 1'b0;
                        sweep_next     = '0;
                        if (epoch_reg == {EPOCH_W{1'b1}})
                        begin
                            epoch_next = EPOCH_W'(1);
                            state_next = ST_WRAP;
                        end
                        else
                        begin
                            epoch_next = epoch_reg + EPOCH_W'(1);
                            state_next = ST_START;
                        end
                    end
                end
            end
            // tag sweep on epoch wrap, walls kept
            ST_WRAP:
            begin
                mem_re    = (sweep_reg != SWEEP_W'(CELL_COUNT));
                mem_raddr = sweep_reg[CELL_W-1:0];
                if (sweep_reg != '0)
                begin
                    mem_we         = 1'b1;
                    mem_waddr      = sweep_dec[CELL_W-1:0];
                    mem_wdata.wall = cell_rd_reg.wall;
                end
                if (sweep_reg == SWEEP_W'(CELL_COUNT))
                begin
                    state_next = ST_START;
                end
                sweep_next = sweep_reg + SWEEP_W'(1);
            end
            ST_START:
            begin
                mem_re     = start_in;
                mem_raddr  = start_addr;
                state_next = ST_CHECK;
            end
            // start cell: mark and push when open
            ST_CHECK:
            begin
                open_next = start_in && !cell_rd_reg.wall;
                if (start_in && !cell_rd_reg.wall)
                begin
                    mem_we        = 1'b1;
                    mem_waddr     = start_addr;
                    mem_wdata.tag = epoch_reg;
                    stk_we        = 1'b1;
                    stk_waddr     = '0;
                    stk_wdata.row = start_row_reg[ROW_W-1:0];
                    stk_wdata.col = start_col_reg[COL_W-1:0];
                    depth_next    = DEPTH_W'(1);
                    state_next    = ST_POP;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_POP:
            begin
                if (depth_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    stk_re     = 1'b1;
                    depth_next = depth_dec;
                    state_next = ST_CELL;
                end
            end
            // popped cell counted, first neighbor read
            ST_CELL:
            begin
                cur_next     = stack_rd_reg;
                count_next   = count_reg + DEPTH_W'(1);
                mem_re       = nb_in;
                mem_raddr    = cell_addr(nb_row, nb_col);
                nb_ok_next   = nb_in;
                nb_next.row  = nb_row[ROW_W-1:0];
                nb_next.col  = nb_col[COL_W-1:0];
                nb_addr_next = cell_addr(nb_row, nb_col);
                probe_next   = NB_DOWN;
                state_next   = ST_PROBE;
            end
            // check one neighbor, read the next unless this was the last
            ST_PROBE:
            begin
                if (push_hit)
                begin
                    mem_we        = 1'b1;
                    mem_waddr     = nb_addr_reg;
                    mem_wdata.tag = epoch_reg;
                    if (depth_reg < DEPTH_W'(CELL_COUNT))
                    begin
                        stk_we     = 1'b1;
                        stk_wdata  = nb_reg;
                        depth_next = depth_reg + DEPTH_W'(1);
                    end
                end
                if (probe_reg == NB_LEFT)
                begin
                    state_next = ST_POP;
                end
                else
                begin
                    mem_re       = nb_in;
                    mem_raddr    = cell_addr(nb_row, nb_col);
                    nb_ok_next   = nb_in;
                    nb_next.row  = nb_row[ROW_W-1:0];
                    nb_next.col  = nb_col[COL_W-1:0];
                    nb_addr_next = cell_addr(nb_row, nb_col);
                    probe_next   = probe_reg + 2'd1;
                end
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            sweep_reg <= '0;
            epoch_reg <= '0;
            depth_reg <= '0;
            count_reg <= '0;
            open_reg  <= 1'b0;
            probe_reg <= NB_DOWN;
            nb_ok_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
            epoch_reg <= epoch_next;
            depth_reg <= depth_next;
            count_reg <= count_next;
            open_reg  <= open_next;
            probe_reg <= probe_next;
            nb_ok_reg <= nb_ok_next;
        end
    end

    // coordinate registers
    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        nb_reg        <= nb_next;
        nb_addr_reg   <= nb_addr_next;
        start_row_reg <= start_row_next;
        start_col_reg <= start_col_next;
    end

    // cell map: wall bit and visited tag
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cell_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            cell_rd_reg <= cell_mem[mem_raddr];
        end
    end

    // coordinate stack
    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stack_mem[stk_waddr] <= stk_wdata;
        end
        if (stk_re)
        begin
            stack_rd_reg <= stack_mem[stk_raddr];
        end
    end

    `GFFC_ASSERT(a_depth_bound, depth_reg <= DEPTH_W'(CELL_COUNT), "stack depth over cell count")
    `GFFC_ASSERT(a_no_rw_clash, !(mem_we && mem_re && (mem_waddr == mem_raddr)), "map read and write hit one cell")
    `GFFC_ASSERT_IMPL(a_closed_empty, res_valid && !open_reg, count_reg == '0, "closed start with nonzero count")
    `GFFC_ASSERT_IMPL(a_idle_empty, state_reg == ST_IDLE, depth_reg == '0, "stack not empty while idle")
    `GFFC_ASSERT_IMPL(a_wrap_epoch, (state_reg == ST_START) && ($past(state_reg) == ST_WRAP), epoch_reg == EPOCH_W'(1), "epoch not restarted after sweep")

endmodule

// ===== design/grid_flood_fill_counter_unit.sv =====
// Four-connected flood fill counter over a stored wall map.
// Items arrive on the item channel (valid/ready). A load item writes one
// cell's wall bit; cells outside the configured rows and columns are
// ignored, and a load gives no result. A fill item names a start cell and
// gives one result item: the number of open cells reached through up,
// down, left and right steps, and whether the start cell was open.
// A load is written as it is taken. A fill works through each reached
// cell in turn, paced by the single read port of the cell map: the pop,
// then four neighbor probes, one map read each. Visited marks are tags;
// the 256th fill after reset, and every 255th fill after that, first
// sweeps the tags. After reset the block runs a clearing pass that opens
// all cells; no item is taken in that time, register writes are.
// Results sit in an output register; a new item is taken while a result
// waits. A fill that ends while the output is still held waits for it.
// Registers grid_rows (0x0) and grid_cols (0x4) reset to 64.
`timescale 1ns / 1ps

module grid_flood_fill_counter_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    gffc_item_if.sink                   item,
    gffc_result_if.source               result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gffc_pkg::ADDR_W-1:0] paddr,
    input  logic [gffc_pkg::DATA_W-1:0] pwdata,
    output logic [gffc_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import gffc_pkg::*;

    logic [CFG_W-1:0]     grid_rows_reg, grid_rows_next;
    logic [CFG_W-1:0]     grid_cols_reg, grid_cols_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_wr;
    logic [LIM_W-1:0]     rows_lim, cols_lim;

    item_t   cmd;
    logic    res_valid, res_ready, res_take;
    result_t res;
    logic    result_valid_reg, result_valid_next;
    result_t result_reg;

    // register port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_comb
    begin
        grid_rows_next = grid_rows_reg;
        grid_cols_next = grid_cols_reg;
        prdata         = '0;
        unique case (reg_idx)
            REG_GRID_ROWS:
            begin
                prdata = DATA_W'(grid_rows_reg);
                if (cfg_wr)
                begin
                    grid_rows_next = pwdata[CFG_W-1:0];
                end
            end
            REG_GRID_COLS:
            begin
                prdata = DATA_W'(grid_cols_reg);
                if (cfg_wr)
                begin
                    grid_cols_next = pwdata[CFG_W-1:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= CFG_W'(64);
            grid_cols_reg <= CFG_W'(64);
        end
        else
        begin
            grid_rows_reg <= grid_rows_next;
            grid_cols_reg <= grid_cols_next;
        end
    end

    // active grid saturates at the map size
    assign rows_lim = (LIM_W'(grid_rows_reg) < LIM_W'(MAX_ROWS)) ?
                      LIM_W'(grid_rows_reg) : LIM_W'(MAX_ROWS);
    assign cols_lim = (LIM_W'(grid_cols_reg) < LIM_W'(MAX_COLS)) ?
                      LIM_W'(grid_cols_reg) : LIM_W'(MAX_COLS);

    // item payload
    assign cmd.kind    = item.kind;
    assign cmd.row     = item.row;
    assign cmd.col     = item.col;
    assign cmd.blocked = item.blocked;

    gffc_walker u_walker (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item       (cmd),
        .item_ready (item.ready),
        .rows_lim   (rows_lim),
        .cols_lim   (cols_lim),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    // output register
    assign res_ready = !result_valid_reg || result.ready;
    assign res_take  = res_valid && res_ready;

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (res_take)
        begin
            result_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            result_reg <= res;
        end
    end

    assign result.valid       = result_valid_reg;
    assign result.region_size = result_reg.region_size;
    assign result.start_open  = result_reg.start_open;

endmodule

// ===== bench/testbench.sv =====
// self-checking bench for the flood fill counter: wall loads, fills, idling, register phases
`timescale 1ns / 1ps

module testbench;
    import gffc_pkg::*;

    localparam int SETTLE_CYCLES = 16;
    localparam int LONG_HOLD     = 600;
    localparam int PHASE_ITEMS   = 110;
    localparam int NUM_PHASES    = 8;
    localparam int REPORT_LIMIT  = 10;

    logic                clk     = 1'b0;
    logic                rst_n   = 1'b0;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [ADDR_W-1:0]   paddr   = '0;
    logic [DATA_W-1:0]   pwdata  = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    gffc_item_if   item_ch ();
    gffc_result_if result_ch ();

    // item offered to the block and the result side ready
    item_t drv_item   = '0;
    logic  drv_valid  = 1'b0;
    logic  sink_ready = 1'b0;

    assign item_ch.valid   = drv_valid;
    assign item_ch.kind    = drv_item.kind;
    assign item_ch.row     = drv_item.row;
    assign item_ch.col     = drv_item.col;
    assign item_ch.blocked = drv_item.blocked;
    assign result_ch.ready = sink_ready;

    grid_flood_fill_counter_unit uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow of the wall map and the grid registers
    bit          wall_bits [CELL_COUNT];
    int          rows_cfg = MAX_ROWS;
    int          cols_cfg = MAX_COLS;

    // items waiting to be sent and fill results still owed
    item_t       pending_items [$];
    result_t     fill_expect [$];

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    bit          hold_request   = 1'b0;
    bit          hold_used      = 1'b0;
    int          hold_left      = 0;
    int          mismatches     = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // cell lies inside the active grid, registers saturating at the map size
    function automatic bit cell_in_grid(input int r, input int c);
        int lim_r;
        int lim_c;
        lim_r = (rows_cfg > MAX_ROWS) ? MAX_ROWS : rows_cfg;
        lim_c = (cols_cfg > MAX_COLS) ? MAX_COLS : cols_cfg;
        return (r >= 0) && (c >= 0) && (r < lim_r) && (c < lim_c);
    endfunction

    function automatic bit cell_open(input int r, input int c);
        return cell_in_grid(r, c) && !wall_bits[r * MAX_COLS + c];
    endfunction

    // size of the 4-connected open region around the start cell
    function automatic result_t count_region(input int r0, input int c0);
        bit      seen [CELL_COUNT];
        int      trail [$];
        int      reached;
        int      idx;
        int      cr;
        int      cc;
        int      nr;
        int      nc;
        result_t res;
        reached = 0;
        res.start_open = cell_open(r0, c0);
        if (res.start_open)
        begin
            seen[r0 * MAX_COLS + c0] = 1'b1;
            trail.push_back(r0 * MAX_COLS + c0);
        end
        while (trail.size() != 0)
        begin
            idx = trail.pop_back();
            reached++;
            cr = idx / MAX_COLS;
            cc = idx % MAX_COLS;
            for (int k = 0; k < 4; k++)
            begin
                nr = cr;
                nc = cc;
                case (k)
                    0: nr = cr + 1;
                    1: nr = cr - 1;
                    2: nc = cc + 1;
                    default: nc = cc - 1;
                endcase
                if (cell_open(nr, nc) && !seen[nr * MAX_COLS + nc])
                begin
                    seen[nr * MAX_COLS + nc] = 1'b1;
                    trail.push_back(nr * MAX_COLS + nc);
                end
            end
        end
        res.region_size = reached[SIZE_W-1:0];
        return res;
    endfunction

    // update the shadow map or owe a result for one accepted item
    function automatic void take_item(input item_t it);
        if (it.kind == KIND_LOAD)
        begin
            if (cell_in_grid(int'(it.row), int'(it.col)))
                wall_bits[int'(it.row) * MAX_COLS + int'(it.col)] = it.blocked;
        end
        else
            fill_expect.push_back(count_region(int'(it.row), int'(it.col)));
    endfunction

    task automatic flag_mismatch(input string what, input int expv, input int actv);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%0t: %s: expected %0d, got %0d", $time, what, expv, actv);
    endtask

    // item driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            drv_valid <= 1'b0;
        else
        begin
            if (drv_valid && item_ch.ready)
                take_item(drv_item);
            if (!drv_valid || item_ch.ready)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    drv_item  <= pending_items.pop_front();
                    drv_valid <= 1'b1;
                end
                else
                    drv_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, armed once
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_used <= 1'b0;
        end
        else if (hold_request && !hold_used)
        begin
            hold_left <= LONG_HOLD;
            hold_used <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sink_ready <= 1'b0;
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (fill_expect.size() == 0)
                    flag_mismatch("result with none owed, region_size", -1,
                                  int'(result_ch.region_size));
                else
                begin
                    if (result_ch.region_size !== fill_expect[0].region_size)
                        flag_mismatch("region_size", int'(fill_expect[0].region_size),
                                      int'(result_ch.region_size));
                    if (result_ch.start_open !== fill_expect[0].start_open)
                        flag_mismatch("start_open", int'(fill_expect[0].start_open),
                                      int'(result_ch.start_open));
                    void'(fill_expect.pop_front());
                end
            end
            sink_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic queue_item(input logic kind, input int r, input int c, input logic blk);
        item_t it;
        it.kind    = kind;
        it.row     = r[ROW_IN_W-1:0];
        it.col     = c[COL_IN_W-1:0];
        it.blocked = blk;
        pending_items.push_back(it);
    endtask

    // wait until every item is sent and every result is back, then let the block settle
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || drv_valid || fill_expect.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= DATA_W'(val);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_GRID_ROWS)
            rows_cfg = val & ((1 << CFG_W) - 1);
        else
            cols_cfg = val & ((1 << CFG_W) - 1);
    endtask

    // bursts of wall edits inside the grid followed by fills, with some noise
    task automatic queue_random(input int target, input int wall_pct);
        int    made;
        int    burst;
        int    lim_r;
        int    lim_c;
        item_t it;
        lim_r = (rows_cfg > MAX_ROWS) ? MAX_ROWS : rows_cfg;
        lim_c = (cols_cfg > MAX_COLS) ? MAX_COLS : cols_cfg;
        made = 0;
        while (made < target)
        begin
            if ($urandom_range(99) < 10)
            begin
                it.kind    = 1'($urandom_range(1));
                it.row     = ROW_IN_W'($urandom);
                it.col     = COL_IN_W'($urandom);
                it.blocked = 1'($urandom_range(1));
                pending_items.push_back(it);
                // loads off the grid do nothing and are not counted
                if (it.kind == KIND_FILL || cell_in_grid(int'(it.row), int'(it.col)))
                    made++;
            end
            else
            begin
                burst = $urandom_range(1, 8);
                repeat (burst)
                    queue_item(KIND_LOAD, $urandom_range(lim_r - 1), $urandom_range(lim_c - 1),
                               $urandom_range(99) < wall_pct);
                made += burst;
                burst = $urandom_range(1, 3);
                repeat (burst)
                    queue_item(KIND_FILL, $urandom_range(lim_r - 1), $urandom_range(lim_c - 1),
                               1'($urandom_range(1)));
                made += burst;
            end
        end
    endtask

    initial
    begin : stimulus
        int rows;
        int cols;
        int mode;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // full grid: whole map open, then corner walls and an isolated cell
        write_reg(REG_GRID_ROWS, MAX_ROWS);
        write_reg(REG_GRID_COLS, MAX_COLS);
        queue_item(KIND_FILL, 0, 0, 1'b0);
        queue_item(KIND_LOAD, 63, 63, 1'b1);
        queue_item(KIND_FILL, 63, 63, 1'b1);
        queue_item(KIND_LOAD, 62, 63, 1'b1);
        queue_item(KIND_LOAD, 63, 62, 1'b1);
        queue_item(KIND_FILL, 0, 63, 1'b0);
        queue_item(KIND_LOAD, 63, 63, 1'b0);
        queue_item(KIND_FILL, 63, 63, 1'b0);
        queue_item(KIND_LOAD, 0, 0, 1'b1);
        queue_item(KIND_FILL, 0, 0, 1'b1);
        queue_item(KIND_LOAD, 0, 0, 1'b0);
        wait_drained();

        // shrunk grid: loads and fills off the grid, blocked start
        write_reg(REG_GRID_ROWS, 3);
        write_reg(REG_GRID_COLS, 2);
        queue_item(KIND_LOAD, 10, 10, 1'b1);
        queue_item(KIND_LOAD, 2, 1, 1'b1);
        queue_item(KIND_FILL, 0, 0, 1'b0);
        queue_item(KIND_FILL, 5, 5, 1'b0);
        queue_item(KIND_FILL, 2, 1, 1'b0);
        queue_item(KIND_LOAD, 2, 1, 1'b0);
        wait_drained();

        // zero rows: empty grid
        write_reg(REG_GRID_ROWS, 0);
        write_reg(REG_GRID_COLS, MAX_COLS);
        queue_item(KIND_LOAD, 0, 0, 1'b1);
        queue_item(KIND_FILL, 0, 0, 1'b0);
        wait_drained();

        // oversize rows saturate, single column
        write_reg(REG_GRID_ROWS, 127);
        write_reg(REG_GRID_COLS, 1);
        queue_item(KIND_FILL, 0, 0, 1'b0);
        queue_item(KIND_FILL, 63, 0, 1'b1);
        wait_drained();

        // random phases over several grid shapes and idling modes
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: begin rows = 8;   cols = 8;   end
                1: begin rows = 1;   cols = 64;  end
                2: begin rows = 64;  cols = 1;   end
                3: begin rows = 5;   cols = 12;  end
                4: begin rows = 16;  cols = 16;  end
                5: begin rows = 3;   cols = 7;   end
                6: begin rows = 100; cols = 2;   end
                default: begin rows = 2; cols = 127; end
            endcase
            write_reg(REG_GRID_ROWS, rows);
            write_reg(REG_GRID_COLS, cols);
            mode = p % 4;
            send_idle_pct  = (mode == 1) ? 72 : (mode == 3) ? 22 : 0;
            recv_stall_pct = (mode == 2) ? 72 : (mode == 3) ? 22 : 0;
            // receiver holds off while the sender keeps offering
            if (p == 0)
                hold_request = 1'b1;
            queue_random(PHASE_ITEMS / 2, $urandom_range(10, 50));
            // sender pauses here until every result is back
            wait_drained();
            queue_random(PHASE_ITEMS - PHASE_ITEMS / 2, $urandom_range(10, 50));
            wait_drained();
        end

        repeat (64) @(negedge clk);
        if (mismatches == 0 && fill_expect.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : watchdog
        #(30_000_000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
